[rtl/pn3o_pkg.sv]
//------------------------------------------------------------------------------
// pn3o_pkg: shared types and constants for the 3-D octave gradient noise block
// Holds default parameters, the command code, the gradient select function and
// the request structure passed from the top level to the noise engine.
//------------------------------------------------------------------------------
`default_nettype none

package pn3o_pkg;

	localparam int TABLE_SIZE  = 256;
	localparam int FRAC_BITS   = 16;
	localparam int MAX_OCTAVES = 8;

	localparam int IDX_W  = 8;
	localparam int ONE_Q16 = 65536;

	// configuration register indexes
	localparam logic [0:0] REG_OCTAVES = 1'b0;
	localparam logic [0:0] REG_PERSIST = 1'b1;

	// commands
	localparam logic CMD_LOAD   = 1'b0;
	localparam logic CMD_SAMPLE = 1'b1;

	typedef struct packed {
		logic [31:0] cx;
		logic [31:0] cy;
		logic [31:0] cz;
		logic [4:0]  octaves;
		logic [15:0] persist;
	} pn3o_req_t;

	// improved-noise gradient: offsets are signed Q.16, 18 bits
	function automatic logic signed [19:0] grad(input logic [3:0] h,
		input logic signed [17:0] x, input logic signed [17:0] y,
		input logic signed [17:0] z);
		logic signed [19:0] u;
		logic signed [19:0] v;
		u = (h < 4'd8) ? 20'(x) : 20'(y);
		v = (h < 4'd4) ? 20'(y) : ((h == 4'd12 || h == 4'd14) ? 20'(x) : 20'(z));
		if (h[0]) u = -u;
		if (h[1]) v = -v;
		return u + v;
	endfunction

endpackage

`default_nettype wire

[rtl/pn3o_engine.sv]
//------------------------------------------------------------------------------
// pn3o_engine: sequenced noise engine
// Holds the permutation memory and computes one octave-summed sample with one
// shared 36x20 multiplier and a restoring divider, step by step.
//------------------------------------------------------------------------------
`default_nettype none

module pn3o_engine #(
	parameter int FRAC_BITS   = pn3o_pkg::FRAC_BITS
) (
	input  wire logic               clk,
	input  wire logic               arst_n,
	input  wire logic               wr_en,
	input  wire logic [7:0]         wr_idx,
	input  wire logic [7:0]         wr_val,
	input  wire logic               start,
	input  wire pn3o_pkg::pn3o_req_t req,
	output logic                    done,
	output logic signed [15:0]      result
);

	localparam int FD = (FRAC_BITS > 16) ? FRAC_BITS - 16 : 0;
	localparam int FU = (FRAC_BITS < 16) ? 16 - FRAC_BITS : 0;

	typedef enum logic [4:0] {
		S_IDLE, S_SPLIT, S_FADE, S_RD_A, S_RD_B, S_HASH, S_CRD, S_CORNER,
		S_LX, S_LY, S_LZ, S_ACC, S_AMP, S_DIV, S_DONE
	} state_t;

	state_t state_q;

	logic [7:0] perm_mem [0:255];
	logic [7:0] rd_addr;
	logic [7:0] rd_data_q;

	always_ff @(posedge clk) begin
		if (wr_en) perm_mem[wr_idx] <= wr_val;
		rd_data_q <= perm_mem[rd_addr];
	end

	// shared multiplier: signed 36 x signed 20
	logic signed [35:0] mul_a;
	logic signed [19:0] mul_b;
	logic signed [55:0] mul_p;
	assign mul_p = mul_a * mul_b;

	pn3o_pkg::pn3o_req_t req_q;
	logic [3:0]  oct_q;
	logic [31:0] sx, sy, sz;
	logic [7:0]  cxi_q, cyi_q, czi_q;
	logic [16:0] fx_q, fy_q, fz_q;
	logic [16:0] fd_q [0:2];
	logic [31:0] tt_q;
	logic [16:0] t3_q;
	logic [19:0] p_q;
	logic [1:0]  ax_q;
	logic [2:0]  sub_q;
	logic [7:0]  a_q, b_q;
	logic [7:0]  h_q [0:3];
	logic [2:0]  hs_q;
	logic [3:0]  gh_q [0:7];
	logic [2:0]  cn_q;
	logic signed [19:0] lv_q [0:7];
	logic [2:0]  li_q;
	logic signed [55:0] total_q;
	logic [20:0] amp_q;
	logic [24:0] maxm_q;
	logic [55:0] num_q;
	logic [55:0] quo_q;
	logic [26:0] rem_q;
	logic [5:0]  dc_q;
	logic        neg_q;
	logic        rdv_q;

	assign sx = req_q.cx << oct_q;
	assign sy = req_q.cy << oct_q;
	assign sz = req_q.cz << oct_q;

	logic [16:0] fsel;
	always_comb begin
		case (ax_q)
			2'd0: fsel = fx_q;
			2'd1: fsel = fy_q;
			default: fsel = fz_q;
		endcase
	end

	// hash read address sequence
	always_comb begin
		rd_addr = 8'd0;
		case (state_q)
			S_RD_A: rd_addr = (sub_q == 3'd0) ? cxi_q : cxi_q + 8'd1;
			S_RD_B: rd_addr = (sub_q == 3'd0) ? a_q : (sub_q == 3'd1) ? a_q + 8'd1
				: (sub_q == 3'd2) ? b_q : b_q + 8'd1;
			S_CRD: rd_addr = h_q[hs_q[2:1]] + 8'(hs_q[0]);
			default: rd_addr = 8'd0;
		endcase
	end

	// corner offsets
	logic signed [17:0] ox, oy, oz;
	always_comb begin
		ox = cn_q[0] ? 18'(fx_q) - 18'sd65536 : 18'(fx_q);
		oy = cn_q[1] ? 18'(fy_q) - 18'sd65536 : 18'(fy_q);
		oz = cn_q[2] ? 18'(fz_q) - 18'sd65536 : 18'(fz_q);
	end

	// lerp operands: level 0 pairs x, level 1 pairs y, level 2 z
	logic signed [19:0] la, lb;
	logic signed [20:0] ldiff;
	logic [16:0] lf;
	always_comb begin
		la = lv_q[{li_q[1:0], 1'b0}];
		lb = lv_q[{li_q[1:0], 1'b1}];
		ldiff = 21'(lb) - 21'(la);
		case (state_q)
			S_LX: lf = fd_q[0];
			S_LY: lf = fd_q[1];
			default: lf = fd_q[2];
		endcase
		mul_a = 36'sd0;
		mul_b = 20'sd0;
		case (state_q)
			S_FADE: begin
				case (sub_q)
					3'd0: begin mul_a = 36'(fsel); mul_b = 20'(fsel); end
					3'd1: begin mul_a = 36'(tt_q[31:16]); mul_b = 20'(fsel); end
					// p reaches 10.0 in Q.16, so it takes the wide operand
					default: begin mul_a = 36'(p_q); mul_b = 20'(t3_q); end
				endcase
			end
			S_LX, S_LY, S_LZ: begin mul_a = 36'(ldiff); mul_b = 20'(lf); end
			S_ACC: begin mul_a = 36'(lv_q[0]); mul_b = 20'(amp_q); end
			S_AMP: begin mul_a = 36'(amp_q); mul_b = 20'({1'b0, req_q.persist}); end
			default: ;
		endcase
	end

	// p = (6t^2 - 15t*2^16 + 10*2^32) >> 16 from the registered full t*t
	logic signed [40:0] ppoly;
	assign ppoly = 41'sd6 * 41'(tt_q) - 41'sd15 * (41'(fsel) <<< 16)
		+ (41'sd10 <<< 32);

	logic signed [55:0] lshift;
	assign lshift = mul_p >>> 16;

	logic [26:0] dtrial;
	assign dtrial = {rem_q[25:0], num_q[55]};

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= S_IDLE;
			done    <= 1'b0;
		end else begin
			done <= (state_q == S_DONE);
			case (state_q)
				S_IDLE: begin
					if (start) begin
						req_q   <= req;
						oct_q   <= 4'd0;
						total_q <= '0;
						amp_q   <= 21'(pn3o_pkg::ONE_Q16);
						maxm_q  <= '0;
						state_q <= S_SPLIT;
					end
				end
				S_SPLIT: begin
					cxi_q <= sx[FRAC_BITS +: 8];
					cyi_q <= sy[FRAC_BITS +: 8];
					czi_q <= sz[FRAC_BITS +: 8];
					fx_q <= 17'(((sx & ((32'd1 << FRAC_BITS) - 1)) >> FD) << FU);
					fy_q <= 17'(((sy & ((32'd1 << FRAC_BITS) - 1)) >> FD) << FU);
					fz_q <= 17'(((sz & ((32'd1 << FRAC_BITS) - 1)) >> FD) << FU);
					ax_q <= 2'd0;
					sub_q <= 3'd0;
					state_q <= S_FADE;
				end
				S_FADE: begin
					case (sub_q)
						3'd0: begin
							tt_q <= mul_p[31:0];
							sub_q <= 3'd1;
						end
						3'd1: begin
							t3_q <= 17'(mul_p >>> 16);
							p_q  <= 20'(ppoly >>> 16);
							sub_q <= 3'd2;
						end
						default: begin
							fd_q[ax_q] <= 17'(mul_p >>> 16);
							sub_q <= 3'd0;
							if (ax_q == 2'd2) begin
								state_q <= S_RD_A;
								rdv_q <= 1'b0;
							end else ax_q <= ax_q + 2'd1;
						end
					endcase
				end
				S_RD_A: begin
					// read issued, data valid in the next cycle
					if (!rdv_q) rdv_q <= 1'b1;
					else begin
						rdv_q <= 1'b0;
						if (sub_q == 3'd0) begin
							a_q <= rd_data_q + cyi_q;
							sub_q <= 3'd1;
						end else begin
							b_q <= rd_data_q + cyi_q;
							sub_q <= 3'd0;
							state_q <= S_RD_B;
						end
					end
				end
				S_RD_B: begin
					if (!rdv_q) rdv_q <= 1'b1;
					else begin
						h_q[sub_q[1:0]] <= rd_data_q + czi_q;
						rdv_q <= 1'b0;
						if (sub_q == 3'd3) begin
							sub_q <= 3'd0;
							hs_q <= 3'd0;
							state_q <= S_CRD;
						end else sub_q <= sub_q + 3'd1;
					end
				end
				S_CRD: begin
					if (!rdv_q) rdv_q <= 1'b1;
					else begin
						// h order AA,AB,BA,BB; hs[0] selects z+1
						gh_q[{hs_q[0], hs_q[2], hs_q[1]}] <= rd_data_q[3:0];
						rdv_q <= 1'b0;
						if (hs_q == 3'd7) begin
							cn_q <= 3'd0;
							state_q <= S_CORNER;
						end else hs_q <= hs_q + 3'd1;
					end
				end
				S_CORNER: begin
					// corner bits: [0]=x [1]=y [2]=z; gh index {z,x,y}
					lv_q[cn_q] <= pn3o_pkg::grad(gh_q[{cn_q[2], cn_q[0], cn_q[1]}],
						ox, oy, oz);
					if (cn_q == 3'd7) begin
						li_q <= 3'd0;
						state_q <= S_LX;
					end else cn_q <= cn_q + 3'd1;
				end
				S_LX: begin
					lv_q[li_q] <= la + 20'(lshift);
					if (li_q == 3'd3) begin li_q <= 3'd0; state_q <= S_LY; end
					else li_q <= li_q + 3'd1;
				end
				S_LY: begin
					lv_q[li_q] <= la + 20'(lshift);
					if (li_q == 3'd1) begin li_q <= 3'd0; state_q <= S_LZ; end
					else li_q <= li_q + 3'd1;
				end
				S_LZ: begin
					lv_q[0] <= la + 20'(lshift);
					state_q <= S_ACC;
				end
				S_ACC: begin
					total_q <= total_q + mul_p;
					maxm_q <= maxm_q + 25'(amp_q);
					state_q <= S_AMP;
				end
				S_AMP: begin
					amp_q <= 21'(mul_p >>> 16);
					if (5'(oct_q) + 5'd1 >= req_q.octaves) begin
						neg_q <= total_q[55];
						num_q <= total_q[55] ? -total_q : total_q;
						rem_q <= '0;
						dc_q <= 6'd0;
						state_q <= S_DIV;
					end else begin
						oct_q <= oct_q + 4'd1;
						state_q <= S_SPLIT;
					end
				end
				S_DIV: begin
					num_q <= num_q << 1;
					if (dtrial >= {maxm_q, 2'b00}) begin
						rem_q <= dtrial - {maxm_q, 2'b00};
						quo_q <= {quo_q[54:0], 1'b1};
					end else begin
						rem_q <= dtrial;
						quo_q <= {quo_q[54:0], 1'b0};
					end
					if (dc_q == 6'd55) state_q <= S_DONE;
					dc_q <= dc_q + 6'd1;
				end
				S_DONE: begin
					if (!neg_q) result <= (quo_q > 56'd32767) ? 16'sd32767 : 16'(quo_q);
					else result <= (quo_q > 56'd32768) ? -16'sd32768 : 16'(-quo_q);
					state_q <= S_IDLE;
				end
				default: state_q <= S_IDLE;
			endcase
		end
	end

endmodule

`default_nettype wire

[rtl/perlin_noise_3d_octaves.sv]
//------------------------------------------------------------------------------
// perlin_noise_3d_octaves: 3-D improved gradient noise summed over octaves
// Top level: handshakes, configuration registers and output register.
//------------------------------------------------------------------------------
// Input channel (valid/stall): command 0 loads one permutation byte and is
// taken with no stall and no result; command 1 computes one sample.
// A sample runs through one shared multiplier under a sequencer: per octave
// a split, 3 fade steps per axis, 14 table reads through the registered port,
// 8 corner gradients, 7 lerps, accumulate and amplitude update; then a
// restoring divide and a final saturation step give the result.
// in_stall is high while a sample is in work or its result waits in the engine.
// Output channel (valid/stall): noise_value is held in a register until taken;
// a finished result waits in the engine while the output is stalled.
// Config channel (valid/ready): index 0 octave_count, 1 persistence; ready is
// always high. Reset sets octave_count 1 and persistence 0x8000; the
// permutation table is not cleared and must be loaded before sampling.
//------------------------------------------------------------------------------
`default_nettype none

module perlin_noise_3d_octaves #(
	parameter int FRAC_BITS   = pn3o_pkg::FRAC_BITS,
	parameter int MAX_OCTAVES = pn3o_pkg::MAX_OCTAVES
) (
	input  wire logic               clk,
	input  wire logic               arst_n,
	input  wire logic               in_valid,
	output logic                    in_stall,
	input  wire logic               command,
	input  wire logic [7:0]         table_index,
	input  wire logic [7:0]         table_value,
	input  wire logic signed [31:0] coord_x,
	input  wire logic signed [31:0] coord_y,
	input  wire logic signed [31:0] coord_z,
	output logic                    out_valid,
	input  wire logic               out_stall,
	output logic signed [15:0]      noise_value,
	input  wire logic               cfg_valid,
	output logic                    cfg_ready,
	input  wire logic               cfg_index,
	input  wire logic [15:0]        cfg_data
);

	logic [3:0]  octaves_q;
	logic [15:0] persist_q;
	logic        busy_q;
	logic        res_hold_q;
	logic        done;
	logic signed [15:0] res;
	logic        acc;
	logic        slot_free;
	logic        res_move;
	pn3o_pkg::pn3o_req_t req;

	assign cfg_ready = 1'b1;
	assign in_stall  = busy_q;
	assign acc       = in_valid & ~in_stall;
	assign slot_free = ~out_valid | ~out_stall;
	assign res_move  = (done | res_hold_q) & slot_free;

	always_comb begin
		req.cx = coord_x;
		req.cy = coord_y;
		req.cz = coord_z;
		req.persist = persist_q;
		if (octaves_q == 4'd0) req.octaves = 5'd1;
		else if (5'(octaves_q) > 5'(MAX_OCTAVES)) req.octaves = 5'(MAX_OCTAVES);
		else req.octaves = 5'(octaves_q);
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			octaves_q  <= 4'd1;
			persist_q  <= 16'h8000;
			busy_q     <= 1'b0;
			res_hold_q <= 1'b0;
			out_valid  <= 1'b0;
		end else begin
			if (cfg_valid) begin
				if (cfg_index == pn3o_pkg::REG_OCTAVES) octaves_q <= cfg_data[3:0];
				else persist_q <= cfg_data;
			end
			if (acc && command == pn3o_pkg::CMD_SAMPLE) busy_q <= 1'b1;
			else if (res_move) busy_q <= 1'b0;
			// engine result stays in its register until the output slot frees
			res_hold_q <= (done | res_hold_q) & ~slot_free;
			if (res_move) begin
				out_valid <= 1'b1;
				noise_value <= res;
			end else if (!out_stall) out_valid <= 1'b0;
		end
	end

	pn3o_engine #(.FRAC_BITS(FRAC_BITS)) u_engine (
		.clk(clk), .arst_n(arst_n),
		.wr_en(acc && command == pn3o_pkg::CMD_LOAD),
		.wr_idx(table_index), .wr_val(table_value),
		.start(acc && command == pn3o_pkg::CMD_SAMPLE),
		.req(req), .done(done), .result(res)
	);

endmodule

`default_nettype wire

[rtl/pn3o_checker.sv]
//------------------------------------------------------------------------------
// pn3o_checker: port-level checks for the noise block
// Watches handshakes and result ordering on the top-level ports.
//------------------------------------------------------------------------------
`default_nettype none

module pn3o_checker (
	input wire logic clk,
	input wire logic arst_n,
	input wire logic in_valid,
	input wire logic in_stall,
	input wire logic command,
	input wire logic out_valid,
	input wire logic out_stall,
	input wire logic [15:0] noise_value
);

	// a sample request leaves the input stalled next cycle
	a_sample_busy: assert property (@(posedge clk) disable iff (!arst_n)
		(in_valid && !in_stall && command) |=> in_stall)
		else $error("sample not held busy");

	// a load never produces a result the next cycle
	a_load_quiet: assert property (@(posedge clk) disable iff (!arst_n)
		(in_valid && !in_stall && !command && !out_valid) |=> !out_valid)
		else $error("load produced a result");

	// handshake outputs are always known out of reset
	a_known: assert property (@(posedge clk) disable iff (!arst_n)
		!$isunknown({in_stall, out_valid}))
		else $error("handshake output unknown");

	a_out_hold: assert property (@(posedge clk) disable iff (!arst_n)
		(out_valid && out_stall) |=> (out_valid && $stable(noise_value)))
		else $error("stalled result changed");

endmodule

bind perlin_noise_3d_octaves pn3o_checker u_chk (
	.clk(clk), .arst_n(arst_n), .in_valid(in_valid), .in_stall(in_stall),
	.command(command), .out_valid(out_valid), .out_stall(out_stall),
	.noise_value(noise_value)
);

`default_nettype wire
